@@ hw/rtl/dotq_pkg.sv @@
// package: shared types and constants of the deadline ordered timer queue
package dotq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam logic [63:0] TimeMax = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_INSERT  = 3'd0,
    ACT_REM_ID  = 3'd1,
    ACT_REM_TAG = 3'd2,
    ACT_SET_TIME = 3'd3,
    ACT_DISPATCH = 3'd4,
    ACT_FIRE    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EXPIRED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_ABSENT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  event_id;
    logic [63:0] expiry_time;
    logic [63:0] tie_deadline;
    logic [31:0] owner_tag;
    logic [63:0] time_now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  fired_id;
    logic [31:0] fired_tag;
    logic        head_due;
    logic [63:0] next_expiry;
    logic [4:0]  occupancy;
    logic        last_of_run;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] timeout;
    logic [63:0] deadline;
    logic [31:0] tag;
    logic [7:0]  id;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_DROP   = 3'd1,
    CMD_PLACE  = 3'd2,
    CMD_REMTAG = 3'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  id;
    logic [31:0] tag;
    entry_t      ins;
  } bcast_t;

  typedef enum logic [4:0] {
    FSM_IDLE  = 5'b00001,
    FSM_PLACE = 5'b00010,
    FSM_DISP  = 5'b00100,
    FSM_OUT   = 5'b01000,
    FSM_PURGE = 5'b10000
  } fsm_e;

endpackage

@@ hw/rtl/deadline_ordered_timer_queue_top.sv @@
// module: top level of the deadline ordered timer queue
// A sorted queue of up to 16 timer events held in a chain of slot cells.
// Request channel: req_valid_i / req_stall_o / req_i (req_t).
// Result channel: rsp_valid_o / rsp_stall_i / rsp_o (rsp_t).
// A request is taken only while the block is idle and no result waits;
// one request is worked at a time. Path from acceptance to result valid:
//   set time, remove id, unused codes: straight to the output state
//   insert, fire: drop on acceptance, then placement pass
//   remove tag: one shift per matching entry plus a final check
//   dispatch: each result removes the due head entry, the next only after
//   the receiver takes the previous result, at most 16 results per request
// The next request is taken once the last result has been taken and the
// block is back in idle.
// Each result sits in an output register until the receiver takes it;
// while the result stalls, the chain holds and no request is taken.
// The last result of a request carries last_of_run.
// Reset empties every slot and sets the current time to zero; slot
// payloads are not cleared, only their valid bits.
module deadline_ordered_timer_queue_top import dotq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_stall_i,
  output rsp_t rsp_o
);

  fsm_e   state_q, state_d;
  req_t   req_q, req_d;
  logic [63:0] now_q;
  logic [4:0]  nres_q;
  logic        rsp_valid_q;
  rsp_t        rsp_q;
  logic [1:0]  pend_st_q, pend_st_d;
  logic [7:0]  pend_id_q, pend_id_d;
  logic [31:0] pend_tag_q, pend_tag_d;
  logic        place_ok_q, place_ok_d;

  bcast_t bc;
  entry_t head;
  entry_t second;
  logic [CntW-1:0] cnt;
  logic   found;
  entry_t fnd;
  logic   tag_any;

  dotq_chain u_chain (
    .clk_i, .rst_ni, .bc_i(bc),
    .head_o(head), .second_o(second), .count_o(cnt), .id_found_o(found),
    .found_o(fnd), .tag_any_o(tag_any)
  );

  logic accept;
  assign req_stall_o = (state_q != FSM_IDLE) || rsp_valid_q;
  assign accept      = req_valid_i && !req_stall_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  logic head_due;
  logic second_due;
  assign head_due   = head.valid && (head.timeout <= now_q);
  assign second_due = second.valid && (second.timeout <= now_q);

  // broadcast: idle drops by id/tag, place inserts, purge tag, disp head
  always_comb begin
    bc       = '0;
    bc.cmd   = CMD_HOLD;
    bc.id    = accept ? req_i.event_id : req_q.event_id;
    bc.tag   = accept ? req_i.owner_tag : req_q.owner_tag;
    bc.ins   = '0;
    if (accept) begin
      case (action_e'(req_i.action))
        ACT_INSERT, ACT_REM_ID, ACT_FIRE: bc.cmd = CMD_DROP;
        ACT_REM_TAG:                      bc.cmd = CMD_REMTAG;
        default:                          bc.cmd = CMD_HOLD;
      endcase
    end else if (state_q == FSM_PLACE) begin
      bc.cmd = place_ok_q ? CMD_PLACE : CMD_HOLD;
      bc.ins.valid    = 1'b1;
      bc.ins.id       = req_q.event_id;
      bc.ins.tag      = pend_tag_q;
      bc.ins.timeout  = req_q.expiry_time;
      bc.ins.deadline = req_q.tie_deadline;
    end else if (state_q == FSM_PURGE) begin
      bc.cmd = CMD_REMTAG;
    end else if (state_q == FSM_DISP && !rsp_valid_q && head_due &&
                 nres_q != 5'(MaxResults)) begin
      bc.cmd = CMD_DROP;
      bc.id  = head.id;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          case (action_e'(req_i.action))
            ACT_INSERT, ACT_FIRE: state_d = FSM_PLACE;
            ACT_REM_TAG:          state_d = FSM_PURGE;
            ACT_DISPATCH:         state_d = FSM_DISP;
            default:              state_d = FSM_OUT;
          endcase
        end
      end
      FSM_PLACE: state_d = FSM_OUT;
      FSM_PURGE: state_d = tag_any ? FSM_PURGE : FSM_OUT;
      FSM_DISP: begin
        if (!rsp_valid_q && !(head_due && nres_q != 5'(MaxResults)))
          state_d = (nres_q == '0) ? FSM_OUT : FSM_IDLE;
      end
      FSM_OUT:   state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  // pending result fields and placement entry taken at acceptance
  always_comb begin
    req_d      = req_i;
    pend_id_d  = '0;
    pend_tag_d = '0;
    pend_st_d  = ST_DONE;
    // room check allowing for the drop pass: reinsert always fits
    place_ok_d = found || (cnt != CntW'(QueueDepth));
    case (action_e'(req_i.action))
      ACT_INSERT: begin
        pend_id_d  = req_i.event_id;
        pend_tag_d = req_i.owner_tag;
        if (!found && cnt == CntW'(QueueDepth)) begin
          pend_st_d  = ST_FULL;
          pend_tag_d = '0;
        end
      end
      ACT_REM_ID, ACT_FIRE: begin
        pend_id_d  = req_i.event_id;
        pend_tag_d = found ? fnd.tag : '0;
        pend_st_d  = found ? ST_DONE : ST_ABSENT;
        if (action_e'(req_i.action) == ACT_FIRE) begin
          req_d.expiry_time  = now_q;
          req_d.tie_deadline = fnd.deadline;
          place_ok_d         = found;
        end
      end
      ACT_REM_TAG: pend_tag_d = req_i.owner_tag;
      default: ;
    endcase
  end

  logic [4:0] occ;
  assign occ = 5'(cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      now_q       <= '0;
      nres_q      <= '0;
      rsp_valid_q <= 1'b0;
      place_ok_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp_valid_q && !rsp_stall_i) rsp_valid_q <= 1'b0;
      if (accept) begin
        nres_q <= '0;
        if (action_e'(req_i.action) == ACT_SET_TIME) now_q <= req_i.time_now;
        place_ok_q <= place_ok_d;
      end
      if (state_q == FSM_OUT) rsp_valid_q <= 1'b1;
      if (bc.cmd == CMD_DROP && state_q == FSM_DISP) begin
        rsp_valid_q <= 1'b1;
        nres_q      <= nres_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_d;
      pend_id_q  <= pend_id_d;
      pend_tag_q <= pend_tag_d;
      pend_st_q  <= pend_st_d;
    end
    if (state_q == FSM_OUT) begin
      rsp_q.status      <= pend_st_q;
      rsp_q.fired_id    <= pend_id_q;
      rsp_q.fired_tag   <= pend_tag_q;
      rsp_q.head_due    <= head_due;
      rsp_q.next_expiry <= head.valid ? head.timeout : TimeMax;
      rsp_q.occupancy   <= occ;
      rsp_q.last_of_run <= 1'b1;
    end
    // head after removal is slot 1
    if (bc.cmd == CMD_DROP && state_q == FSM_DISP) begin
      rsp_q.status      <= ST_EXPIRED;
      rsp_q.fired_id    <= head.id;
      rsp_q.fired_tag   <= head.tag;
      rsp_q.head_due    <= second_due;
      rsp_q.next_expiry <= second.valid ? second.timeout : TimeMax;
      rsp_q.occupancy   <= occ - 5'd1;
      rsp_q.last_of_run <= !(second_due && (nres_q + 5'd1) != 5'(MaxResults));
    end
  end

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q != FSM_IDLE) |-> !accept;
  endproperty
  assert property (p_no_accept_busy) else $error("request taken while busy");

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt <= CntW'(QueueDepth);
  endproperty
  assert property (p_count_bound) else $error("count over depth");

  property p_disp_limit;
    @(posedge clk_i) disable iff (!rst_ni) nres_q <= 5'(MaxResults);
  endproperty
  assert property (p_disp_limit) else $error("dispatch over limit");

endmodule

@@ hw/rtl/dotq_cell.sv @@
// module: one queue slot, shifts left on removal and right on insertion
module dotq_cell import dotq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  bcast_t bc_i,
  input  entry_t left_i,
  input  entry_t right_i,
  input  logic   left_hit_i,
  input  logic   left_goes_i,
  output entry_t self_o,
  output logic   hit_o,
  output logic   goes_o
);

  logic        valid_q;
  logic [63:0] timeout_q;
  logic [63:0] deadline_q;
  logic [31:0] tag_q;
  logic [7:0]  id_q;
  entry_t cur, d_d;
  logic   hit, goes;
  logic   dropped;

  assign cur = '{valid: valid_q, timeout: timeout_q, deadline: deadline_q,
                 tag: tag_q, id: id_q};

  // removal marker for this slot, and prefix of removals from the left
  always_comb begin
    case (bc_i.cmd)
      CMD_DROP:   hit = cur.valid && (cur.id == bc_i.id) && !left_hit_i;
      CMD_REMTAG: hit = cur.valid && (cur.tag == bc_i.tag) && !left_hit_i;
      default:    hit = 1'b0;
    endcase
    // insert goes before this slot when the slot is empty or the new entry sorts strictly earlier
    goes = !cur.valid ||
           (bc_i.ins.timeout < cur.timeout) ||
           ((bc_i.ins.timeout == cur.timeout) && (bc_i.ins.deadline < cur.deadline));
  end

  assign dropped = left_hit_i || hit;
  assign hit_o   = dropped;
  assign goes_o  = goes;
  assign self_o  = cur;

  always_comb begin
    d_d = cur;
    case (bc_i.cmd)
      CMD_DROP, CMD_REMTAG: begin
        if (dropped) d_d = right_i;
      end
      CMD_PLACE: begin
        if (left_goes_i) d_d = left_i;
        else if (goes) d_d = bc_i.ins;
      end
      default: d_d = cur;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    timeout_q  <= d_d.timeout;
    deadline_q <= d_d.deadline;
    tag_q      <= d_d.tag;
    id_q       <= d_d.id;
  end

endmodule

@@ hw/rtl/dotq_chain.sv @@
// module: row of slot cells with neighbor links
module dotq_chain import dotq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  bcast_t bc_i,
  output entry_t head_o,
  output entry_t second_o,
  output logic [CntW-1:0] count_o,
  output logic   id_found_o,
  output entry_t found_o,
  output logic   tag_any_o
);

  entry_t slot [QueueDepth];
  logic   hit  [QueueDepth];
  logic   goes [QueueDepth];
  entry_t empty_e;

  assign empty_e = '0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    entry_t lft, rgt;
    logic   lh, lg;
    if (i == 0) begin : g_first
      assign lft = empty_e;
      assign lh  = 1'b0;
      assign lg  = 1'b0;
    end else begin : g_rest
      assign lft = slot[i-1];
      assign lh  = hit[i-1];
      assign lg  = goes[i-1];
    end
    if (i == QueueDepth - 1) begin : g_last
      assign rgt = empty_e;
    end else begin : g_mid
      assign rgt = slot[i+1];
    end
    dotq_cell u_cell (
      .clk_i, .rst_ni, .bc_i,
      .left_i(lft), .right_i(rgt), .left_hit_i(lh), .left_goes_i(lg),
      .self_o(slot[i]), .hit_o(hit[i]), .goes_o(goes[i])
    );
  end

  assign head_o   = slot[0];
  assign second_o = slot[1];

  always_comb begin
    count_o    = '0;
    id_found_o = 1'b0;
    found_o    = '0;
    tag_any_o  = 1'b0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (slot[i].valid) count_o = count_o + CntW'(1);
      if (slot[i].valid && slot[i].tag == bc_i.tag) tag_any_o = 1'b1;
      if (slot[i].valid && slot[i].id == bc_i.id && !id_found_o) begin
        id_found_o = 1'b1;
        found_o    = slot[i];
      end
    end
  end

endmodule

@@ bench/testbench.sv @@
// testbench for the deadline ordered timer queue: random and directed requests, scoreboard check
`timescale 1ns / 100ps

module testbench;
  import dotq_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  rsp_t rsp_o;

  deadline_ordered_timer_queue_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_stall_o(req_stall_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_stall_i(rsp_stall_i), .rsp_o(rsp_o)
  );

  always #5 clk_i = ~clk_i;

  req_t pending_q[$];
  rsp_t timer_rsp_q[$];
  int errors = 0;
  int n_checked = 0;
  int n_fired = 0;
  bit idling_on = 1'b1;

  // shadow copy of the timer queue
  logic [63:0] sh_timeout[QueueDepth];
  logic [63:0] sh_deadline[QueueDepth];
  logic [31:0] sh_tag[QueueDepth];
  logic [7:0]  sh_id[QueueDepth];
  int sh_count = 0;
  logic [63:0] sh_now = '0;

  function automatic int find_event(logic [7:0] id);
    for (int i = 0; i < sh_count; i++)
      if (sh_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_event(int pos);
    if (pos < 0 || pos >= sh_count) return;
    for (int i = pos; i + 1 < sh_count; i++) begin
      sh_timeout[i] = sh_timeout[i+1];
      sh_deadline[i] = sh_deadline[i+1];
      sh_tag[i] = sh_tag[i+1];
      sh_id[i] = sh_id[i+1];
    end
    sh_count--;
  endfunction

  function automatic bit place_event(logic [63:0] t, logic [63:0] d, logic [31:0] tag,
                                     logic [7:0] id);
    int pos;
    pos = 0;
    if (sh_count >= QueueDepth) return 1'b0;
    while (pos < sh_count && !(t < sh_timeout[pos] ||
           (t == sh_timeout[pos] && d < sh_deadline[pos])))
      pos++;
    for (int i = sh_count; i > pos; i--) begin
      sh_timeout[i] = sh_timeout[i-1];
      sh_deadline[i] = sh_deadline[i-1];
      sh_tag[i] = sh_tag[i-1];
      sh_id[i] = sh_id[i-1];
    end
    sh_timeout[pos] = t;
    sh_deadline[pos] = d;
    sh_tag[pos] = tag;
    sh_id[pos] = id;
    sh_count++;
    return 1'b1;
  endfunction

  function automatic rsp_t timer_result(status_e st, logic [7:0] id, logic [31:0] tag);
    rsp_t r;
    r.status = st;
    r.fired_id = id;
    r.fired_tag = tag;
    r.head_due = (sh_count > 0) && (sh_timeout[0] <= sh_now);
    r.next_expiry = (sh_count > 0) ? sh_timeout[0] : TimeMax;
    r.occupancy = sh_count[4:0];
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic void predict_timer(req_t rq);
    rsp_t run_q[$];
    rsp_t tmp;
    int pos;
    logic [63:0] d;
    logic [31:0] t;
    case (rq.action)
      ACT_INSERT: begin
        drop_event(find_event(rq.event_id));
        if (place_event(rq.expiry_time, rq.tie_deadline, rq.owner_tag, rq.event_id))
          run_q.push_back(timer_result(ST_DONE, rq.event_id, rq.owner_tag));
        else
          run_q.push_back(timer_result(ST_FULL, rq.event_id, '0));
      end
      ACT_REM_ID: begin
        pos = find_event(rq.event_id);
        if (pos < 0) begin
          run_q.push_back(timer_result(ST_ABSENT, rq.event_id, '0));
        end else begin
          t = sh_tag[pos];
          drop_event(pos);
          run_q.push_back(timer_result(ST_DONE, rq.event_id, t));
        end
      end
      ACT_REM_TAG: begin
        pos = 0;
        while (pos < sh_count) begin
          if (sh_tag[pos] == rq.owner_tag) drop_event(pos);
          else pos++;
        end
        run_q.push_back(timer_result(ST_DONE, '0, rq.owner_tag));
      end
      ACT_SET_TIME: begin
        sh_now = rq.time_now;
        run_q.push_back(timer_result(ST_DONE, '0, '0));
      end
      ACT_DISPATCH: begin
        while (run_q.size() < MaxResults && sh_count > 0 && sh_timeout[0] <= sh_now) begin
          pos = sh_id[0];
          t = sh_tag[0];
          drop_event(0);
          run_q.push_back(timer_result(ST_EXPIRED, pos[7:0], t));
        end
        if (run_q.size() == 0) run_q.push_back(timer_result(ST_DONE, '0, '0));
      end
      ACT_FIRE: begin
        pos = find_event(rq.event_id);
        if (pos < 0) begin
          run_q.push_back(timer_result(ST_ABSENT, rq.event_id, '0));
        end else begin
          d = sh_deadline[pos];
          t = sh_tag[pos];
          drop_event(pos);
          void'(place_event(sh_now, d, t, rq.event_id));
          run_q.push_back(timer_result(ST_DONE, rq.event_id, t));
        end
      end
      default: run_q.push_back(timer_result(ST_DONE, '0, '0));
    endcase
    tmp = run_q.pop_back();
    tmp.last_of_run = 1'b1;
    run_q.push_back(tmp);
    foreach (run_q[i]) timer_rsp_q.push_back(run_q[i]);
  endfunction

  // request driver
  int req_gap = 0;
  always @(posedge clk_i) begin
    bit taken;
    taken = req_valid_i && !req_stall_o;
    if (rst_ni) begin
      if (taken) predict_timer(req_i);
      if (!req_valid_i || taken) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          req_valid_i <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
          req_gap <= $urandom_range(0, 4);
          req_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req_i <= pending_q.pop_front();
          req_valid_i <= 1'b1;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int rsp_gap = 0;
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_o && !rsp_stall_i) begin
        n_checked++;
        if (rsp_o.status == ST_EXPIRED) n_fired++;
        if (timer_rsp_q.size() == 0) begin
          errors++;
          $display("%t unexpected result: actual %p", $time, rsp_o);
        end else begin
          want = timer_rsp_q.pop_front();
          if (rsp_o !== want) begin
            errors++;
            $display("%t mismatch: expected %p actual %p", $time, want, rsp_o);
          end
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        rsp_gap <= $urandom_range(0, 4);
        rsp_stall_i <= 1'b1;
      end else begin
        rsp_stall_i <= 1'b0;
      end
    end
  end

  function automatic req_t make_req(action_e a, logic [7:0] id, logic [63:0] t,
                                    logic [63:0] d, logic [31:0] tag, logic [63:0] now);
    req_t r;
    r.action = a;
    r.event_id = id;
    r.expiry_time = t;
    r.tie_deadline = d;
    r.owner_tag = tag;
    r.time_now = now;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    req_t r;
    logic [63:0] base;
    int pick;
    // directed part
    pending_q.push_back(make_req(ACT_DISPATCH, 8'd0, 64'd0, 64'd0, 32'd0, 64'd0));
    pending_q.push_back(make_req(ACT_INSERT, 8'hFF, TimeMax, TimeMax, 32'hFFFF_FFFF,
                                 64'd0));
    pending_q.push_back(make_req(ACT_INSERT, 8'd0, 64'd0, 64'd5, 32'h1, 64'd0));
    pending_q.push_back(make_req(ACT_INSERT, 8'd1, 64'd0, 64'd5, 32'h1, TimeMax));
    pending_q.push_back(make_req(ACT_INSERT, 8'd2, 64'd0, 64'd0, 32'h2, 64'd0));
    pending_q.push_back(make_req(ACT_INSERT, 8'd0, 64'd10, 64'd1, 32'h1, 64'd0));
    pending_q.push_back(make_req(ACT_REM_ID, 8'd9, 64'd0, 64'd0, 32'd0, 64'd0));
    pending_q.push_back(make_req(ACT_FIRE, 8'd9, 64'd0, 64'd0, 32'd0, 64'd0));
    pending_q.push_back(make_req(ACT_FIRE, 8'hFF, 64'd0, 64'd0, 32'd0, 64'd0));
    pending_q.push_back(make_req(ACT_REM_ID, 8'd2, 64'd0, 64'd0, 32'd0, 64'd0));
    pending_q.push_back(make_req(ACT_REM_TAG, 8'd0, 64'd0, 64'd0, 32'h1, 64'd0));
    pending_q.push_back(make_req(action_e'(3'd6), 8'hAA, rand64(), rand64(), $urandom, rand64()));
    pending_q.push_back(make_req(action_e'(3'd7), 8'h55, rand64(), rand64(), $urandom, rand64()));
    for (int i = 0; i < 17; i++)
      pending_q.push_back(make_req(ACT_INSERT, 8'(i + 16), 64'(i % 3), 64'(i % 2), 32'h7,
                                   64'd0));
    pending_q.push_back(make_req(ACT_SET_TIME, 8'd0, 64'd0, 64'd0, 32'd0, TimeMax));
    pending_q.push_back(make_req(ACT_DISPATCH, 8'd0, 64'd0, 64'd0, 32'd0, 64'd0));
    pending_q.push_back(make_req(ACT_SET_TIME, 8'd0, 64'd0, 64'd0, 32'd0, 64'd0));
    // random part
    base = 0;
    for (int i = 0; i < 240; i++) begin
      pick = $urandom_range(0, 99);
      r.event_id = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
      r.owner_tag = ($urandom_range(0, 5) == 0) ? $urandom : 32'($urandom_range(0, 3));
      r.expiry_time = ($urandom_range(0, 9) == 0) ? rand64() : base + $urandom_range(0, 300);
      r.tie_deadline = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 3));
      r.time_now = rand64();
      if (pick < 38) r.action = ACT_INSERT;
      else if (pick < 48) r.action = ACT_REM_ID;
      else if (pick < 55) r.action = ACT_REM_TAG;
      else if (pick < 68) begin
        r.action = ACT_SET_TIME;
        if ($urandom_range(0, 7) != 0) begin
          base = base + $urandom_range(0, 150);
          r.time_now = base;
        end
      end
      else if (pick < 85) r.action = ACT_DISPATCH;
      else if (pick < 96) r.action = ACT_FIRE;
      else r.action = action_e'(3'($urandom_range(6, 7)));
      pending_q.push_back(r);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() < 40);
    idling_on = 1'b0;
    wait (pending_q.size() == 0 && !req_valid_i && timer_rsp_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("covered %0d results, %0d expired deliveries, all request kinds incl. full queue",
             n_checked, n_fired);
    if (errors == 0 && timer_rsp_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/dotq_pkg.sv
hw/rtl/dotq_cell.sv
hw/rtl/dotq_chain.sv
hw/rtl/deadline_ordered_timer_queue_top.sv
bench/testbench.sv
